// ===== rtl/bis_pkg.sv =====
package bis_pkg;

	localparam int MAX_ROWS  = 256;
	localparam int MAX_COLS  = 256;
	localparam int FRAC_BITS = 12;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;

	localparam int IDX_W  = 12;
	localparam int STEP_W = 16;
	localparam int SIZE_W = 9;
	localparam int CHAN_W = 8;
	localparam int PIX_W  = 3 * CHAN_W;
	localparam int POS_W  = IDX_W + STEP_W;
	localparam int IP_W   = POS_W - FRAC_BITS;

	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COL_STEP    = 2'd3;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] source_rows;
		logic [SIZE_W-1:0] source_cols;
		logic [STEP_W-1:0] row_step;
		logic [STEP_W-1:0] col_step;
	} bis_cfg_t;

	// one classified transaction; for a load r0/c0 hold the store address
	typedef struct packed {
		logic                 req;
		logic [ROW_W-1:0]     r0;
		logic [COL_W-1:0]     c0;
		logic [FRAC_BITS-1:0] fr;
		logic [FRAC_BITS-1:0] fc;
		logic                 border;
		logic                 beyond;
		logic [PIX_W-1:0]     pix;
	} bis_cmd_t;

	function automatic logic [IP_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [IP_W-1:0] maxv);
		logic [IP_W-1:0] w;
		w = IP_W'(v);
		if (w == '0)
			return IP_W'(1);
		if (w > maxv)
			return maxv;
		return w;
	endfunction

	// (a*(1-w) + b*w), truncated
	function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b, input logic [FRAC_BITS-1:0] w);
		logic [FRAC_BITS:0]          wa;
		logic [CHAN_W+FRAC_BITS+1:0] acc;
		wa  = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, w};
		acc = (CHAN_W+FRAC_BITS+2)'(a) * (CHAN_W+FRAC_BITS+2)'(wa)
			+ (CHAN_W+FRAC_BITS+2)'(b) * (CHAN_W+FRAC_BITS+2)'(w);
		return acc[FRAC_BITS +: CHAN_W];
	endfunction

endpackage

// ===== rtl/bilinear_image_scaler_top.sv =====
// Channel    Handshake         Payload
// ---------  ----------------  ----------------------------------------------------
// command    start / busy      command, row, col, in_red, in_green, in_blue
// result     done (1 cycle)    out_red, out_green, out_blue, border_copy, beyond_source
// config     cfg_we            cfg_idx, cfg_data
//
// A transaction is taken when start is high and busy is low. The front stage
// maps it (one multiply per axis, then clamp and border test) and drops it into
// a four-entry queue; loads outside the frame store are discarded instead. The
// back end writes a load to the frame store as it leaves the queue's head; a
// request steps through IDLE, ROW0, ROW1 and MIX: two passes over the two read
// ports of the frame store, then the row blend. done is registered from MIX.
// Reset clears control state only; the frame store is not cleared. The result
// side cannot stall; busy rises only when the queue is full.
module bilinear_image_scaler_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            command,
	input  logic [bis_pkg::IDX_W-1:0]       row,
	input  logic [bis_pkg::IDX_W-1:0]       col,
	input  logic [bis_pkg::CHAN_W-1:0]      in_red,
	input  logic [bis_pkg::CHAN_W-1:0]      in_green,
	input  logic [bis_pkg::CHAN_W-1:0]      in_blue,
	output logic                            done,
	output logic [bis_pkg::CHAN_W-1:0]      out_red,
	output logic [bis_pkg::CHAN_W-1:0]      out_green,
	output logic [bis_pkg::CHAN_W-1:0]      out_blue,
	output logic                            border_copy,
	output logic                            beyond_source,
	input  logic                            cfg_we,
	input  logic [bis_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bis_pkg::*;

	bis_cfg_t cfg_q;
	logic     q_push, q_full, q_pop, q_valid;
	bis_cmd_t q_in, q_head;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_rows <= SIZE_W'(256);
			cfg_q.source_cols <= SIZE_W'(256);
			cfg_q.row_step    <= STEP_W'(4096);
			cfg_q.col_step    <= STEP_W'(4096);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SOURCE_ROWS: cfg_q.source_rows <= cfg_data[SIZE_W-1:0];
				REG_SOURCE_COLS: cfg_q.source_cols <= cfg_data[SIZE_W-1:0];
				REG_ROW_STEP:    cfg_q.row_step    <= cfg_data[STEP_W-1:0];
				REG_COL_STEP:    cfg_q.col_step    <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// front: accept, map to source position, classify
	bis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.row       (row),
		.col       (col),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.busy      (busy),
		.push      (q_push),
		.push_data (q_in)
	);

	// decouples mapping from the frame store accesses
	bis_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	// back: frame store writes, neighbor reads, blending
	bis_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.done          (done),
		.out_red       (out_red),
		.out_green     (out_green),
		.out_blue      (out_blue),
		.border_copy   (border_copy),
		.beyond_source (beyond_source)
	);

endmodule

// ===== rtl/bis_front.sv =====
module bis_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    command,
	input  logic [bis_pkg::IDX_W-1:0]  row,
	input  logic [bis_pkg::IDX_W-1:0]  col,
	input  logic [bis_pkg::CHAN_W-1:0] in_red,
	input  logic [bis_pkg::CHAN_W-1:0] in_green,
	input  logic [bis_pkg::CHAN_W-1:0] in_blue,
	input  bis_pkg::bis_cfg_t       cfg,
	input  logic                    q_full,
	output logic                    busy,
	output logic                    push,
	output bis_pkg::bis_cmd_t       push_data
);
	import bis_pkg::*;

	logic                 v_s1;
	logic                 req_s1;
	logic                 keep_s1;
	logic [POS_W-1:0]     pos_r_s1;
	logic [POS_W-1:0]     pos_c_s1;
	logic [ROW_W-1:0]     ld_row_s1;
	logic [COL_W-1:0]     ld_col_s1;
	logic [PIX_W-1:0]     pix_s1;
	logic                 acc;

	logic [IP_W-1:0]      srows, scols, ir, ic;
	logic [FRAC_BITS-1:0] fr, fc;
	logic                 beyond, border;

	assign busy = v_s1 && q_full;
	assign acc  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (!q_full) begin
			v_s1 <= 1'b0;
		end
	end

	// mapping products are taken straight off the input ports
	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1    <= (command == CMD_REQUEST);
			keep_s1   <= (command == CMD_REQUEST) ||
				((IDX_W+1)'(row) < (IDX_W+1)'(MAX_ROWS) &&
				 (IDX_W+1)'(col) < (IDX_W+1)'(MAX_COLS));
			pos_r_s1  <= POS_W'(row) * POS_W'(cfg.row_step);
			pos_c_s1  <= POS_W'(col) * POS_W'(cfg.col_step);
			ld_row_s1 <= row[ROW_W-1:0];
			ld_col_s1 <= col[COL_W-1:0];
			pix_s1    <= {in_red, in_green, in_blue};
		end
	end

	always_comb begin
		srows  = clamp_size(cfg.source_rows, IP_W'(MAX_ROWS));
		scols  = clamp_size(cfg.source_cols, IP_W'(MAX_COLS));
		ir     = pos_r_s1[POS_W-1:FRAC_BITS];
		fr     = pos_r_s1[FRAC_BITS-1:0];
		ic     = pos_c_s1[POS_W-1:FRAC_BITS];
		fc     = pos_c_s1[FRAC_BITS-1:0];
		beyond = 1'b0;
		if (ir >= srows) begin
			ir     = srows - IP_W'(1);
			fr     = '0;
			beyond = 1'b1;
		end
		if (ic >= scols) begin
			ic     = scols - IP_W'(1);
			fc     = '0;
			beyond = 1'b1;
		end
		border = (ir + IP_W'(1) >= srows) || (ic + IP_W'(1) >= scols);

		push_data.req    = req_s1;
		push_data.r0     = req_s1 ? ir[ROW_W-1:0] : ld_row_s1;
		push_data.c0     = req_s1 ? ic[COL_W-1:0] : ld_col_s1;
		push_data.fr     = fr;
		push_data.fc     = fc;
		push_data.border = border;
		push_data.beyond = beyond;
		push_data.pix    = pix_s1;
	end

	// out-of-store loads are dropped here
	assign push = v_s1 && !q_full && keep_s1;

endmodule

// ===== rtl/bis_queue.sv =====
module bis_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bis_pkg::bis_cmd_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output bis_pkg::bis_cmd_t head
);
	import bis_pkg::*;

	bis_cmd_t          entry_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/bis_back.sv =====
module bis_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  bis_pkg::bis_cmd_t          q_head,
	output logic                       q_pop,
	output logic                       done,
	output logic [bis_pkg::CHAN_W-1:0] out_red,
	output logic [bis_pkg::CHAN_W-1:0] out_green,
	output logic [bis_pkg::CHAN_W-1:0] out_blue,
	output logic                       border_copy,
	output logic                       beyond_source
);
	import bis_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROW0 = 2'd1;
	localparam logic [1:0] ST_ROW1 = 2'd2;
	localparam logic [1:0] ST_MIX  = 2'd3;

	logic [1:0]        state_q;
	bis_cmd_t          job_q;
	logic [PIX_W-1:0]  frame_store_q [2**ADDR_W];
	logic [PIX_W-1:0]  rd_a_q, rd_b_q, px00_q;
	logic [CHAN_W-1:0] top_q [3];
	logic [CHAN_W-1:0] bot_q [3];
	logic [CHAN_W-1:0] res_q [3];
	logic              done_q, border_q, beyond_q;

	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] addr_a, addr_b;
	logic [ROW_W-1:0]  rd_row;
	logic [COL_W-1:0]  rd_col;

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign wr_en = q_pop && !q_head.req;
	assign rd_en = (q_pop && q_head.req) || (state_q == ST_ROW0);

	// first pass reads the upper pair, second pass the lower pair
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_row = q_head.r0;
			rd_col = q_head.c0;
		end else begin
			rd_row = job_q.r0 + ROW_W'(1);
			rd_col = job_q.c0;
		end
		addr_a = {rd_row, rd_col};
		addr_b = {rd_row, rd_col + COL_W'(1)};
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			frame_store_q[{q_head.r0, q_head.c0}] <= q_head.pix;
		if (rd_en) begin
			rd_a_q <= frame_store_q[addr_a];
			rd_b_q <= frame_store_q[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_MIX);
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_head.req)
						state_q <= ST_ROW0;
				end
				ST_ROW0: state_q <= ST_ROW1;
				ST_ROW1: state_q <= ST_MIX;
				ST_MIX:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_head;
		if (state_q == ST_ROW0) begin
			px00_q <= rd_a_q;
			for (int k = 0; k < 3; k++)
				top_q[k] <= blend(rd_a_q[PIX_W-1-k*CHAN_W -: CHAN_W],
					rd_b_q[PIX_W-1-k*CHAN_W -: CHAN_W], job_q.fc);
		end
		if (state_q == ST_ROW1) begin
			for (int k = 0; k < 3; k++)
				bot_q[k] <= blend(rd_a_q[PIX_W-1-k*CHAN_W -: CHAN_W],
					rd_b_q[PIX_W-1-k*CHAN_W -: CHAN_W], job_q.fc);
		end
		if (state_q == ST_MIX) begin
			border_q <= job_q.border;
			beyond_q <= job_q.beyond;
			for (int k = 0; k < 3; k++)
				res_q[k] <= job_q.border ? px00_q[PIX_W-1-k*CHAN_W -: CHAN_W]
					: blend(top_q[k], bot_q[k], job_q.fr);
		end
	end

	assign done          = done_q;
	assign out_red       = res_q[0];
	assign out_green     = res_q[1];
	assign out_blue      = res_q[2];
	assign border_copy   = border_q;
	assign beyond_source = beyond_q;

`ifndef SYNTHESIS
	a_done_after_mix: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_MIX))
		else $error("result strobe without a final blend");
	a_row1_after_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW1) |-> $past(state_q == ST_ROW0))
		else $error("lower row read without upper row");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW0) |-> !$past(wr_en))
		else $error("store write overlapped a request");
`endif

endmodule

// ===== dv/bilinear_image_scaler_top_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the bilinear scaler.
// The scoreboard predicts every requested output pixel from its own copy of the
// frame store and of the four registers; loads only update that copy.
// Requests are generated so that every store entry they read has been loaded.
// A request whose neighbours are missing gets them loaded first, with random
// content. That load-then-request sequence is the bulk of the random traffic.
// Config writes happen only with the block drained.
module bilinear_image_scaler_top_tb;
	import bis_pkg::*;

	// time for loads left in the queue after the last result to drain
	localparam int DRAIN_CYCLES = 24;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              border;
		logic              beyond;
	} scaled_pixel_t;

	class scaler_scoreboard;
		logic [PIX_W-1:0]  frame [MAX_ROWS*MAX_COLS];
		bit                loaded [MAX_ROWS*MAX_COLS];
		logic [SIZE_W-1:0] rows_reg;
		logic [SIZE_W-1:0] cols_reg;
		logic [STEP_W-1:0] rstep_reg;
		logic [STEP_W-1:0] cstep_reg;
		scaled_pixel_t     expected_q[$];
		int                errors;

		function new();
			rows_reg  = 9'd256;
			cols_reg  = 9'd256;
			rstep_reg = 16'd4096;
			cstep_reg = 16'd4096;
			errors    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_SOURCE_ROWS: rows_reg  = data[SIZE_W-1:0];
			REG_SOURCE_COLS: cols_reg  = data[SIZE_W-1:0];
			REG_ROW_STEP:    rstep_reg = data[STEP_W-1:0];
			REG_COL_STEP:    cstep_reg = data[STEP_W-1:0];
			endcase
		endfunction

		// zero counts as one, anything past the store saturates
		function int unsigned fit_size(logic [SIZE_W-1:0] v, int unsigned limit);
			if (v == 0)
				return 1;
			if (v > limit)
				return limit;
			return 32'(v);
		endfunction

		function int unsigned eff_rows();
			return fit_size(rows_reg, MAX_ROWS);
		endfunction

		function int unsigned eff_cols();
			return fit_size(cols_reg, MAX_COLS);
		endfunction

		function void map_axis(input int unsigned idx, input int unsigned step,
			input int unsigned size, output int unsigned ip, output int unsigned fr,
			inout bit beyond);
			int unsigned pos;
			pos = idx * step;
			ip  = pos >> FRAC_BITS;
			fr  = pos & ((1 << FRAC_BITS) - 1);
			if (ip >= size) begin
				ip     = size - 1;
				fr     = 0;
				beyond = 1'b1;
			end
		endfunction

		function void locate(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
			output int unsigned r0, output int unsigned c0, output int unsigned fr,
			output int unsigned fc, output bit border, output bit beyond);
			beyond = 1'b0;
			map_axis(row, rstep_reg, eff_rows(), r0, fr, beyond);
			map_axis(col, cstep_reg, eff_cols(), c0, fc, beyond);
			border = (r0 + 1 >= eff_rows()) || (c0 + 1 >= eff_cols());
		endfunction

		function int unsigned mix(int unsigned a, int unsigned b, int unsigned w);
			return ((a * ((1 << FRAC_BITS) - w) + b * w) >> FRAC_BITS) & 8'hFF;
		endfunction

		// columns first, then rows; each stage truncated
		function logic [CHAN_W-1:0] bilerp(logic [CHAN_W-1:0] a00, logic [CHAN_W-1:0] a01,
			logic [CHAN_W-1:0] a10, logic [CHAN_W-1:0] a11,
			int unsigned fr, int unsigned fc);
			return CHAN_W'(mix(mix(a00, a01, fc), mix(a10, a11, fc), fr));
		endfunction

		function void note_command(logic cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
			logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
			int unsigned      r0, c0, fr, fc, a;
			bit               border, beyond;
			logic [PIX_W-1:0] p00, p01, p10, p11;
			scaled_pixel_t    px;
			if (cmd == CMD_LOAD) begin
				if (row < MAX_ROWS && col < MAX_COLS) begin
					a         = row * MAX_COLS + col;
					frame[a]  = {r, g, b};
					loaded[a] = 1'b1;
				end
				return;
			end
			locate(row, col, r0, c0, fr, fc, border, beyond);
			a   = r0 * MAX_COLS + c0;
			p00 = frame[a];
			if (border) begin
				{px.red, px.green, px.blue} = p00;
			end else begin
				p01 = frame[a + 1];
				p10 = frame[a + MAX_COLS];
				p11 = frame[a + MAX_COLS + 1];
				px.red   = bilerp(p00[23:16], p01[23:16], p10[23:16], p11[23:16], fr, fc);
				px.green = bilerp(p00[15:8], p01[15:8], p10[15:8], p11[15:8], fr, fc);
				px.blue  = bilerp(p00[7:0], p01[7:0], p10[7:0], p11[7:0], fr, fc);
			end
			px.border = border;
			px.beyond = beyond;
			expected_q.push_back(px);
		endfunction

		function void compare(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
			if (got !== want) begin
				$display("%0t MISMATCH %s: expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
			logic [CHAN_W-1:0] b, logic border, logic beyond);
			scaled_pixel_t want;
			if (expected_q.size() == 0) begin
				$display("%0t MISMATCH result: expected none, actual %h %h %h border %b beyond %b",
					$time, r, g, b, border, beyond);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare("out_red", want.red, r);
			compare("out_green", want.green, g);
			compare("out_blue", want.blue, b);
			compare("border_copy", CHAN_W'(want.border), CHAN_W'(border));
			compare("beyond_source", CHAN_W'(want.beyond), CHAN_W'(beyond));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  command;
	logic [IDX_W-1:0]      row;
	logic [IDX_W-1:0]      col;
	logic [CHAN_W-1:0]     in_red;
	logic [CHAN_W-1:0]     in_green;
	logic [CHAN_W-1:0]     in_blue;
	logic                  done;
	logic [CHAN_W-1:0]     out_red;
	logic [CHAN_W-1:0]     out_green;
	logic [CHAN_W-1:0]     out_blue;
	logic                  border_copy;
	logic                  beyond_source;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	scaler_scoreboard sb;
	int               gap_pct;	// chance (percent) of an idle burst before a transaction
	int               sent;		// command transactions taken so far

	bilinear_image_scaler_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling; a healthy run ends far earlier
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// done is a one-cycle strobe: every cycle it is high carries a result
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_pixel(out_red, out_green, out_blue, border_copy, beyond_source);
	end

	// One command transaction. Fields change on the falling edge; the transaction
	// is taken on the first rising edge with busy low. start stays high into the
	// next transaction unless an idle burst drops it.
	task automatic send_item(logic cmd, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
		logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green, logic [CHAN_W-1:0] blue);
		int n;
		if ($urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 7);
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		start    <= 1'b1;
		command  <= cmd;
		row      <= r;
		col      <= c;
		in_red   <= red;
		in_green <= green;
		in_blue  <= blue;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(cmd, r, c, red, green, blue);
		sent++;
	endtask

	task automatic load_pixel(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
		send_item(CMD_LOAD, r, c, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
	endtask

	// Request one output pixel; any neighbour it reads that was never loaded is
	// loaded just ahead of it, so the request also exercises load/read ordering.
	task automatic request_pixel(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
		int unsigned r0, c0, fr, fc, span;
		bit          border, beyond;
		sb.locate(r, c, r0, c0, fr, fc, border, beyond);
		span = border ? 0 : 1;
		for (int unsigned dr = 0; dr <= span; dr++)
			for (int unsigned dc = 0; dc <= span; dc++)
				if (!sb.loaded[(r0 + dr) * MAX_COLS + c0 + dc])
					load_pixel(IDX_W'(r0 + dr), IDX_W'(c0 + dc));
		// color inputs are don't-care for a request; random keeps them toggling
		send_item(CMD_REQUEST, r, c, CHAN_W'($urandom), CHAN_W'($urandom),
			CHAN_W'($urandom));
	endtask

	// Stop sending and wait until every predicted pixel came back, then give
	// trailing loads time to leave the queue.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
		logic [CFG_DATA_W-1:0] rstep, logic [CFG_DATA_W-1:0] cstep);
		settle();
		write_reg(REG_SOURCE_ROWS, rows);
		write_reg(REG_SOURCE_COLS, cols);
		write_reg(REG_ROW_STEP, rstep);
		write_reg(REG_COL_STEP, cstep);
	endtask

	// Output index aimed at a random source position from the first row/column
	// to just past the last, so interior, border and clamped
	// cases all show up; now and then any index at all.
	function automatic logic [IDX_W-1:0] pick_index(int unsigned step, int unsigned size);
		int unsigned t, v;
		if (step == 0 || $urandom_range(0, 7) == 0)
			return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
		t = $urandom_range(0, size + 1);
		v = ((t << FRAC_BITS) + $urandom_range(0, (1 << FRAC_BITS) - 1)) / step;
		return (v > (1 << IDX_W) - 1) ? IDX_W'((1 << IDX_W) - 1) : IDX_W'(v);
	endfunction

	// every transaction sent counts, neighbour loads included
	task automatic run_phase(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
		logic [CFG_DATA_W-1:0] rstep, logic [CFG_DATA_W-1:0] cstep, int items, int gaps);
		int          target;
		int unsigned kind;
		configure(rows, cols, rstep, cstep);
		gap_pct = gaps;
		target  = sent + items;
		while (sent < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				request_pixel(pick_index(sb.rstep_reg, sb.eff_rows()),
					pick_index(sb.cstep_reg, sb.eff_cols()));
			end else if (kind < 88) begin
				// overwrite inside the source area
				load_pixel(IDX_W'($urandom_range(0, sb.eff_rows() - 1)),
					IDX_W'($urandom_range(0, sb.eff_cols() - 1)));
			end else begin
				// anywhere: mostly outside the store and dropped
				load_pixel(IDX_W'($urandom), IDX_W'($urandom));
			end
			// now and then let the pipe run completely dry mid-phase
			if ($urandom_range(0, 149) == 0)
				settle();
		end
	endtask

	initial begin
		sb       = new();
		gap_pct  = 0;
		sent     = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		command  = CMD_LOAD;
		row      = '0;
		col      = '0;
		in_red   = '0;
		in_green = '0;
		in_blue  = '0;
		cfg_we   = 1'b0;
		cfg_idx  = REG_SOURCE_ROWS;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, 256x256 source, unit steps
		send_item(CMD_LOAD, 0, 0, 8'h00, 8'h00, 8'h00);
		send_item(CMD_LOAD, 0, 1, 8'hFF, 8'hFF, 8'hFF);
		send_item(CMD_LOAD, 1, 0, 8'hFF, 8'hFF, 8'hFF);
		send_item(CMD_LOAD, 1, 1, 8'h00, 8'h00, 8'h00);
		send_item(CMD_LOAD, IDX_W'(MAX_ROWS - 1), IDX_W'(MAX_COLS - 1), 8'hFF, 8'h00, 8'hFF);
		// loads outside the store must be dropped, not wrapped onto row/col 0
		send_item(CMD_LOAD, 12'hFFF, 12'hFFF, 8'h5A, 8'hA5, 8'h3C);
		send_item(CMD_LOAD, IDX_W'(MAX_ROWS), 0, 8'h11, 8'h22, 8'h33);
		send_item(CMD_LOAD, 0, IDX_W'(MAX_COLS), 8'h44, 8'h55, 8'h66);
		request_pixel(0, 0);                 // interior, zero fractions
		request_pixel(IDX_W'(MAX_ROWS - 1), IDX_W'(MAX_COLS - 1));  // bottom-right border
		request_pixel(12'hFFF, 12'hFFF);     // past the source on both axes
		// zero sizes count as one; zero steps pin every index to 0
		configure(0, 0, 0, 0);
		request_pixel(12'hFFF, 12'hFFF);
		request_pixel(1, 1);
		// oversize rows saturate; half-row step; column step at its maximum
		configure(16'h01FF, 2, 16'h0800, 16'hFFFF);
		request_pixel(1, 0);                 // half-way between rows 0 and 1
		request_pixel(0, 1);                 // column clamped, border copy
		request_pixel(12'hFFF, 0);           // row clamped to the last row

		// random phases, extremes first
		run_phase(8, 8, 16'h0800, 16'h0800, 110, 30);
		run_phase(256, 256, 16'h1000, 16'h1000, 90, 10);
		run_phase(1, 256, 16'h0400, 16'h2800, 60, 30);
		run_phase(16'h012C, 5, 16'hFFFF, 16'h0001, 60, 0);
		run_phase(16'hFFFF, 2, 16'h0001, 16'hFFFF, 60, 20);
		run_phase(2, 2, 16'h0C00, 16'h0555, 60, 30);
		repeat (5) begin
			run_phase(($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24)),
				($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24)),
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h0200, 16'h3000)),
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h0200, 16'h3000)),
				70, $urandom_range(0, 2) * 20);
		end
		// closing stretch at full rate, no idle cycles
		run_phase(12, 7, 16'h0AAB, 16'h1800, 80, 0);
		run_phase(64, 64, 16'h0F00, 16'h1100, 80, 0);

		settle();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
